>>> hdl/sspm_pkg.sv
// Shared types, constants and register indexes for the speed sensor plausibility monitor.
package sspm_pkg;

  // Field widths
  localparam int SpeedW   = 8;
  localparam int DayW     = 16;
  localparam int TickW    = 9;
  localparam int RunW     = TickW + 1;
  localparam int GapW     = 4;
  localparam int RepW     = 3;
  localparam int PctW     = 8;
  localparam int VerdictW = 2;
  localparam int DiffProdW  = SpeedW + 7;
  localparam int LimitProdW = PctW + 1 + SpeedW;

  // Stream word widths
  localparam int InDataW  = 40;
  localparam int OutDataW = 32;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 9;

  // Register reset values
  localparam logic [SpeedW-1:0] MinGpsRst    = 8'd40;
  localparam logic [PctW-1:0]   FaultPctRst  = 8'd11;
  localparam logic [TickW-1:0]  RecordRst    = 9'd60;
  localparam logic [TickW-1:0]  DecideRst    = 9'd300;
  localparam logic [GapW-1:0]   AlarmGapRst  = 4'd10;
  localparam logic [RepW-1:0]   AlarmRepRst  = 3'd3;

  // Scale factor for the percentage test
  localparam logic [6:0] Percent = 7'd100;

  // Verdict codes
  localparam logic [VerdictW-1:0] VERDICT_NONE     = 2'd0;
  localparam logic [VerdictW-1:0] VERDICT_NORMAL   = 2'd1;
  localparam logic [VerdictW-1:0] VERDICT_ABNORMAL = 2'd2;

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_MIN_GPS_SPEED = 3'd0,
    CFG_FAULT_PERCENT = 3'd1,
    CFG_RECORD_TICKS  = 3'd2,
    CFG_DECIDE_TICKS  = 3'd3,
    CFG_ALARM_GAP     = 3'd4,
    CFG_ALARM_REPEATS = 3'd5
  } cfg_idx_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
  } dp_cmd_t;

endpackage

>>> hdl/sspm_ctrl.sv
// Controller state machine: sequences capture, multiply and update of one word.
module sspm_ctrl import sspm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_UPD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_blocked;

  // The result register is free when empty or being taken this cycle
  assign out_blocked = out_valid_r && !out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  assign cmd.load = in_tvalid && (state_r == S_IDLE);
  assign cmd.mul  = (state_r == S_MUL);
  assign cmd.upd  = (state_r == S_UPD) && !out_blocked;

  // Next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!out_blocked) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/sspm_dp.sv
// Datapath: configuration registers, deviation test, run counters, verdict and alarm state.
module sspm_dp import sspm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output logic [OutDataW-1:0] out_tdata
);

  // Configuration registers
  logic [SpeedW-1:0] min_gps_r;
  logic [PctW-1:0]   fault_pct_r;
  logic [TickW-1:0]  record_r;
  logic [TickW-1:0]  decide_r;
  logic [GapW-1:0]   alarm_gap_r;
  logic [RepW-1:0]   alarm_rep_r;

  // Captured input word
  logic [SpeedW-1:0] gps_r;
  logic [SpeedW-1:0] pulse_r;
  logic              fixed_r;
  logic [DayW-1:0]   day_r;

  // Products for the deviation test
  logic [DiffProdW-1:0]  diff_prod_r;
  logic [LimitProdW-1:0] limit_prod_r;

  // Monitor state
  logic [VerdictW-1:0] verdict_r, verdict_nxt;
  logic [DayW-1:0]     vday_r, vday_nxt;
  logic                vday_valid_r, vday_valid_nxt;
  logic [RunW-1:0]     good_run_r, good_run_nxt;
  logic [RunW-1:0]     bad_run_r, bad_run_nxt;
  logic [RepW:0]       alarm_cnt_r, alarm_cnt_nxt;
  logic [GapW:0]       alarm_dly_r, alarm_dly_nxt;

  logic [OutDataW-1:0] out_r, out_nxt;

  logic [SpeedW-1:0] diff;
  logic              day_done;
  logic              bad;
  logic [RunW-1:0]   run;
  logic [GapW:0]     dly_inc;
  logic              run_started, sample_valid, decided, alarm;
  logic [TickW-1:0]  sample_index;
  logic [SpeedW-1:0] s_pulse, s_gps;

  assign diff = (pulse_r >= gps_r) ? (pulse_r - gps_r) : (gps_r - pulse_r);

  // floor(diff*100/gps) > pct is the same as diff*100 >= (pct+1)*gps; a zero pulse speed passes
  assign bad = (pulse_r != '0) && (diff_prod_r >= limit_prod_r);
  assign run = bad ? (bad_run_r + 1'b1) : (good_run_r + 1'b1);
  assign day_done = vday_valid_r && (vday_r == day_r);
  assign dly_inc  = alarm_dly_r + 1'b1;

  // Update of the monitor state for one tick
  always_comb begin
    verdict_nxt    = verdict_r;
    vday_nxt       = vday_r;
    vday_valid_nxt = vday_valid_r;
    good_run_nxt   = good_run_r;
    bad_run_nxt    = bad_run_r;
    alarm_cnt_nxt  = alarm_cnt_r;
    alarm_dly_nxt  = alarm_dly_r;
    run_started    = 1'b0;
    sample_valid   = 1'b0;
    sample_index   = '0;
    s_pulse        = '0;
    s_gps          = '0;
    decided        = 1'b0;
    alarm          = 1'b0;

    // Alarm sequence runs ahead of judging
    if (alarm_cnt_r != '0 && verdict_r == VERDICT_ABNORMAL) begin
      alarm_dly_nxt = dly_inc;
      if (dly_inc > {1'b0, alarm_gap_r}) begin
        alarm_dly_nxt = '0;
        if (alarm_cnt_r > {1'b0, alarm_rep_r}) begin
          alarm_cnt_nxt = '0;
        end else begin
          alarm_cnt_nxt = alarm_cnt_r + 1'b1;
          alarm         = 1'b1;
        end
      end
    end

    if (!day_done) begin
      if (!fixed_r || gps_r < min_gps_r) begin
        alarm_dly_nxt = '0;
        alarm_cnt_nxt = '0;
        good_run_nxt  = '0;
        bad_run_nxt   = '0;
      end else begin
        if (bad) begin
          bad_run_nxt  = run;
          good_run_nxt = '0;
        end else begin
          good_run_nxt = run;
          bad_run_nxt  = '0;
        end
        run_started = (run == RunW'(1));
        if (run <= {1'b0, record_r}) begin
          sample_valid = 1'b1;
          sample_index = TickW'(run - 1'b1);
          s_pulse      = pulse_r;
          s_gps        = gps_r;
        end else if (run >= {1'b0, decide_r}) begin
          verdict_nxt    = bad ? VERDICT_ABNORMAL : VERDICT_NORMAL;
          vday_nxt       = day_r;
          vday_valid_nxt = 1'b1;
          good_run_nxt   = '0;
          bad_run_nxt    = '0;
          alarm_cnt_nxt  = (RepW+1)'(1);
          alarm_dly_nxt  = {1'b0, alarm_gap_r};
          decided        = 1'b1;
        end
      end
    end

    out_nxt = {alarm, decided, s_gps, s_pulse, sample_index, sample_valid, run_started,
               (verdict_nxt == VERDICT_ABNORMAL), verdict_nxt};
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gps_r   <= MinGpsRst;
      fault_pct_r <= FaultPctRst;
      record_r    <= RecordRst;
      decide_r    <= DecideRst;
      alarm_gap_r <= AlarmGapRst;
      alarm_rep_r <= AlarmRepRst;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MIN_GPS_SPEED: min_gps_r   <= cfg_wdata[SpeedW-1:0];
        CFG_FAULT_PERCENT: fault_pct_r <= cfg_wdata[PctW-1:0];
        CFG_RECORD_TICKS:  record_r    <= cfg_wdata[TickW-1:0];
        CFG_DECIDE_TICKS:  decide_r    <= cfg_wdata[TickW-1:0];
        CFG_ALARM_GAP:     alarm_gap_r <= cfg_wdata[GapW-1:0];
        CFG_ALARM_REPEATS: alarm_rep_r <= cfg_wdata[RepW-1:0];
        default: ;
      endcase
    end
  end

  // Input capture, products and result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gps_r   <= in_tdata[7:0];
      pulse_r <= in_tdata[15:8];
      fixed_r <= in_tdata[16];
      day_r   <= in_tdata[32:17];
    end
    if (cmd.mul) begin
      diff_prod_r  <= DiffProdW'(diff) * DiffProdW'(Percent);
      limit_prod_r <= (LimitProdW'(fault_pct_r) + LimitProdW'(1)) * LimitProdW'(gps_r);
    end
    if (cmd.upd) begin
      out_r <= out_nxt;
    end
  end

  // Monitor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verdict_r    <= VERDICT_NONE;
      vday_r       <= '0;
      vday_valid_r <= 1'b0;
      good_run_r   <= '0;
      bad_run_r    <= '0;
      alarm_cnt_r  <= '0;
      alarm_dly_r  <= '0;
    end else if (cmd.upd) begin
      verdict_r    <= verdict_nxt;
      vday_r       <= vday_nxt;
      vday_valid_r <= vday_valid_nxt;
      good_run_r   <= good_run_nxt;
      bad_run_r    <= bad_run_nxt;
      alarm_cnt_r  <= alarm_cnt_nxt;
      alarm_dly_r  <= alarm_dly_nxt;
    end
  end

  assign out_tdata = out_r;

endmodule

>>> hdl/speed_sensor_plausibility_monitor.sv
// Top level of the speed sensor plausibility monitor.
// Each input word is one one-second tick and yields exactly one result word. A word
// is captured at the accepting edge, the two multiplications of the deviation test
// (8 by 7 and 9 by 8 bits) are registered at the next edge, and then the run counters,
// verdict and alarm state are updated and the result register is loaded. The next
// word is accepted once the previous one has reached the result register, so the
// block does not take a new word while one is still in flight; the update, and with it
// the next acceptance, stalls while a previous result has not been taken.
// Configuration registers must be written by the user only while the block is idle;
// the block itself does not enforce this.
module speed_sensor_plausibility_monitor import sspm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // Input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  // gps_speed[7:0], pulse_speed[15:8], position_fixed[16], day_number[32:17], zero pad
  input  logic [InDataW-1:0]  in_tdata,
  // Result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  // verdict[1:0], abnormal_flag[2], run_started[3], sample_valid[4],
  // sample_index[13:5], sample_pulse[21:14], sample_gps[29:22], decided[30], alarm[31]
  output logic [OutDataW-1:0] out_tdata,
  // Configuration write port
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  dp_cmd_t cmd;

  // Sequencing
  sspm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Arithmetic and state
  sspm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata)
  );

endmodule
